// File: rtl/core/cns_pkg.sv
// ---------------------------------------------------------------------------
// cns_pkg: shared types, constants and microprogram of the noise shaper
// Holds the number formats, the filter constants, the control word layout
// and the read-only program that steps the shared multiplier datapath.
// ---------------------------------------------------------------------------
package cns_pkg;

   // Sample width and stream word width (whole bytes).
   localparam int SAMPLE_BITS = 16;
   localparam int DATA_W      = ((SAMPLE_BITS + 7) / 8) * 8;

   // Fixed-point fraction widths.
   localparam int FRAC_COEF = 30;
   localparam int FRAC_GAIN = 15;
   localparam int FRAC_TAP  = 24;

   // Shift from white*gain to the Q8.24 gained noise.
   localparam int SHIFT_N         = SAMPLE_BITS - 1 + FRAC_GAIN - FRAC_TAP;
   // Shift from the final product to a sample, for white and for the filters.
   localparam int OUT_SHIFT_WHITE = FRAC_GAIN;
   localparam int OUT_SHIFT_FILT  = FRAC_GAIN + FRAC_TAP - (SAMPLE_BITS - 1);

   // Datapath widths.
   localparam int OP_W   = 32;
   localparam int PROD_W = 2 * OP_W;
   localparam int SUM_W  = 36;
   localparam int SPLIT  = 18;

   // Pink filter storage.
   localparam int NUM_TAPS = 7;
   localparam int IDX_W    = 3;
   localparam logic [IDX_W-1:0] LAST_POLE  = IDX_W'(5);
   localparam logic [IDX_W-1:0] DELAY_TAP  = IDX_W'(6);

   // Configuration register indexes.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_IDX_W-1:0] REG_MODE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_B0   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_A1   = 2'd3;

   // Mode codes; the fourth code behaves as white.
   localparam logic [1:0] MODE_WHITE = 2'd0;
   localparam logic [1:0] MODE_PINK  = 2'd1;
   localparam logic [1:0] MODE_BROWN = 2'd2;

   // Register reset values.
   localparam logic [15:0]        GAIN_RESET = 16'd8231;
   localparam logic [29:0]        B0_RESET   = 30'd701690;
   localparam logic signed [30:0] A1_RESET   = -31'sd1072338443;

   // Pink filter constants, Q2.30.
   localparam logic signed [OP_W-1:0] PINK_DIRECT = 32'sd575740366;
   localparam logic signed [OP_W-1:0] PINK_DELAY  = 32'sd124474595;
   localparam logic signed [OP_W-1:0] PINK_SCALE  = 32'sd118111601;

   // Saturation limits.
   localparam logic signed [PROD_W-1:0] TAP_MAX = PROD_W'(64'sh0000_0000_7FFF_FFFF);
   localparam logic signed [PROD_W-1:0] TAP_MIN = -TAP_MAX - PROD_W'(1);
   localparam logic signed [PROD_W-1:0] SMP_MAX = (PROD_W'(1) <<< (SAMPLE_BITS - 1)) - 1;
   localparam logic signed [PROD_W-1:0] SMP_MIN = -SMP_MAX - PROD_W'(1);

   // Program counter.
   localparam int PC_W = 5;
   localparam logic [PC_W-1:0] ADDR_START = 5'd0;
   localparam logic [PC_W-1:0] ADDR_PINK  = 5'd4;
   localparam logic [PC_W-1:0] ADDR_BROWN = 5'd17;

   typedef enum logic [2:0] {
      A_WHITE, A_TAP, A_N, A_SUMLO, A_SUMHI, A_ACCQ, A_MEM
   } a_sel_type;

   typedef enum logic [3:0] {
      B_GAIN, B_POLE, B_FEED, B_DIRECT, B_DELAY, B_SCALE, B_B0, B_FB, B_G120
   } b_sel_type;

   typedef enum logic [1:0] {
      ACC_NONE, ACC_LOAD, ACC_ADD, ACC_ADD_SH
   } acc_op_type;

   typedef enum logic [3:0] {
      WB_NONE, WB_N, WB_TAP, WB_SUM_TAP6, WB_SUM_DIRECT, WB_TAP6, WB_MEM,
      WB_OUT_N, WB_OUT_F
   } wb_op_type;

   typedef enum logic [1:0] {
      IDX_HOLD, IDX_CLR, IDX_INC
   } idx_op_type;

   typedef enum logic [1:0] {
      JMP_NEXT, JMP_MODE, JMP_LOOP
   } jmp_type;

   typedef struct packed {
      a_sel_type        a_sel;
      b_sel_type        b_sel;
      acc_op_type       acc_op;
      wb_op_type        wb_op;
      idx_op_type       idx_op;
      jmp_type          jmp;
      logic [PC_W-1:0]  target;
      logic             last;
   } ctl_word_type;

   // Pole coefficients of the six one-pole sections.
   function automatic logic signed [OP_W-1:0] pole_coef(input logic [IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 32'sd1072517758;
         3'd1:    return 32'sd1066569229;
         3'd2:    return 32'sd1040455827;
         3'd3:    return 32'sd930397290;
         3'd4:    return 32'sd590558003;
         3'd5:    return -32'sd817761773;
         default: return '0;
      endcase
   endfunction

   // Input coefficients of the six one-pole sections.
   function automatic logic signed [OP_W-1:0] feed_coef(input logic [IDX_W-1:0] idx);
      case (idx)
         3'd0:    return 32'sd59611891;
         3'd1:    return 32'sd80612134;
         3'd2:    return 32'sd165197327;
         3'd3:    return 32'sd333381374;
         3'd4:    return 32'sd572253067;
         3'd5:    return -32'sd18144089;
         default: return '0;
      endcase
   endfunction

   function automatic logic signed [OP_W-1:0] sat_tap(input logic signed [PROD_W-1:0] v);
      if (v > TAP_MAX) begin
         return TAP_MAX[OP_W-1:0];
      end else if (v < TAP_MIN) begin
         return TAP_MIN[OP_W-1:0];
      end
      return v[OP_W-1:0];
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] sat_sample(input logic signed [PROD_W-1:0] v);
      if (v > SMP_MAX) begin
         return SMP_MAX[SAMPLE_BITS-1:0];
      end else if (v < SMP_MIN) begin
         return SMP_MIN[SAMPLE_BITS-1:0];
      end
      return v[SAMPLE_BITS-1:0];
   endfunction

   // The microprogram. A product issued in one step is in the product
   // register in the next and in the accumulator one step later.
   function automatic ctl_word_type ucode(input logic [PC_W-1:0] pc);
      ctl_word_type w;
      w = '{a_sel: A_WHITE, b_sel: B_GAIN, acc_op: ACC_NONE, wb_op: WB_NONE,
            idx_op: IDX_HOLD, jmp: JMP_NEXT, target: ADDR_START, last: 1'b0};
      case (pc)
         // Gained noise, common to every mode.
         5'd0: begin
            w.a_sel = A_WHITE; w.b_sel = B_GAIN; w.idx_op = IDX_CLR;
         end
         5'd1: begin
            w.acc_op = ACC_LOAD;
         end
         5'd2: begin
            w.wb_op = WB_N; w.jmp = JMP_MODE;
         end
         5'd3: begin
            w.wb_op = WB_OUT_N; w.last = 1'b1;
         end
         // Pink: one pass of this loop per one-pole section.
         5'd4: begin
            w.a_sel = A_TAP; w.b_sel = B_POLE;
         end
         5'd5: begin
            w.a_sel = A_N; w.b_sel = B_FEED; w.acc_op = ACC_LOAD;
         end
         5'd6: begin
            w.acc_op = ACC_ADD;
         end
         5'd7: begin
            w.wb_op = WB_TAP; w.idx_op = IDX_INC; w.jmp = JMP_LOOP;
            w.target = ADDR_PINK;
         end
         5'd8: begin
            w.a_sel = A_N; w.b_sel = B_DIRECT; w.wb_op = WB_SUM_TAP6;
         end
         5'd9: begin
            w.a_sel = A_N; w.b_sel = B_DELAY; w.acc_op = ACC_LOAD;
         end
         5'd10: begin
            w.acc_op = ACC_LOAD; w.wb_op = WB_SUM_DIRECT;
         end
         5'd11: begin
            w.a_sel = A_SUMLO; w.b_sel = B_SCALE; w.wb_op = WB_TAP6;
         end
         5'd12: begin
            w.a_sel = A_SUMHI; w.b_sel = B_SCALE; w.acc_op = ACC_LOAD;
         end
         5'd13: begin
            w.acc_op = ACC_ADD_SH;
         end
         5'd14: begin
            w.a_sel = A_ACCQ; w.b_sel = B_GAIN;
         end
         5'd15: begin
            w.acc_op = ACC_LOAD;
         end
         5'd16: begin
            w.wb_op = WB_OUT_F; w.last = 1'b1;
         end
         // Brown: one-pole recursion, then scale by 120 times the gain.
         5'd17: begin
            w.a_sel = A_N; w.b_sel = B_B0;
         end
         5'd18: begin
            w.a_sel = A_MEM; w.b_sel = B_FB; w.acc_op = ACC_LOAD;
         end
         5'd19: begin
            w.acc_op = ACC_ADD;
         end
         5'd20: begin
            w.wb_op = WB_MEM;
         end
         5'd21: begin
            w.a_sel = A_MEM; w.b_sel = B_G120;
         end
         5'd22: begin
            w.acc_op = ACC_LOAD;
         end
         5'd23: begin
            w.wb_op = WB_OUT_F; w.last = 1'b1;
         end
         default: begin
            w.last = 1'b1;
         end
      endcase
      return w;
   endfunction

endpackage

// File: rtl/core/colored_noise_shaper.sv
// ---------------------------------------------------------------------------
// colored_noise_shaper: white, pink and brown noise shaping of a sample stream
// One white noise word in, one shaped and saturated word out, computed by a
// small microprogram on a single shared 32x32 multiplier and accumulator.
// ---------------------------------------------------------------------------
// Each input word is one uniform white noise sample; each yields exactly one
// shaped sample. The block works on one word at a time and accepts the next
// word only after the program for the previous one has ended. The program
// runs 4 steps in white mode, 10 in brown mode and 36 in pink mode, issuing
// at most one product per cycle to the one shared multiplier; pink mode runs
// four steps for each of its six filter sections. The result sits in an
// output register, so a stalled result side only holds the block at the last
// step of the next word. The mode, gain and brown coefficients are written
// through the csr_ port; the user must write them only while the block is
// idle, which the block itself does not enforce. Pink taps and the brown
// memory are kept across mode changes and cleared only by reset.
// ---------------------------------------------------------------------------
module colored_noise_shaper
   import cns_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   // Input words.
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [DATA_W-1:0]      req_tdata,   // [SAMPLE_BITS-1:0] white_sample
   // Result words.
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [DATA_W-1:0]      rsp_tdata,   // [SAMPLE_BITS-1:0] shaped_sample
   // Configuration writes.
   input  logic                   csr_wr_en,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // Configuration registers.
   logic [1:0]         mode_ff, mode_in;
   logic [15:0]        gain_ff, gain_in;
   logic [29:0]        b0_ff, b0_in;
   logic signed [30:0] a1_ff, a1_in;

   // Sequencer.
   logic               busy_ff, busy_in;
   logic [PC_W-1:0]    pc_ff, pc_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   ctl_word_type       ctl;

   // Datapath.
   logic signed [SAMPLE_BITS-1:0] white_ff, white_in;
   logic signed [PROD_W-1:0]      p_ff, p_in;
   logic signed [PROD_W-1:0]      acc_ff, acc_in;
   logic signed [OP_W-1:0]        n_ff, n_in;
   logic signed [SUM_W-1:0]       sum_ff, sum_in;
   logic signed [OP_W-1:0]        taps_ff [NUM_TAPS];
   logic signed [OP_W-1:0]        taps_in [NUM_TAPS];
   logic signed [OP_W-1:0]        mem_ff, mem_in;

   // Output register.
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                   req_accept;
   logic                   out_step;
   logic                   stall;
   logic                   advance;
   logic signed [OP_W-1:0] a_op;
   logic signed [OP_W-1:0] b_op;
   logic signed [OP_W-1:0] tap_sel;
   logic signed [OP_W-1:0] sat_acc;
   logic [OP_W-1:0]        gain_ext;

   assign req_tready = !busy_ff;
   assign req_accept = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = DATA_W'(rsp_data_ff);

   // The current control word comes straight from the program table.
   assign ctl = ucode(pc_ff);

   // The output step waits while the previous result has not been taken.
   assign out_step = (ctl.wb_op == WB_OUT_N) || (ctl.wb_op == WB_OUT_F);
   assign stall    = out_step && rsp_valid_ff && !rsp_tready;
   assign advance  = busy_ff && !stall;

   assign gain_ext = {{(OP_W-16){1'b0}}, gain_ff};
   assign tap_sel  = (idx_ff < IDX_W'(NUM_TAPS)) ? taps_ff[idx_ff] : '0;
   // Saturated Q8.24 view of the accumulator after the coefficient shift.
   assign sat_acc  = sat_tap(acc_ff >>> FRAC_COEF);

   // Configuration writes.
   always_comb begin
      mode_in = mode_ff;
      gain_in = gain_ff;
      b0_in   = b0_ff;
      a1_in   = a1_ff;
      if (csr_wr_en) begin
         case (csr_index)
            REG_MODE: mode_in = csr_wdata[1:0];
            REG_GAIN: gain_in = csr_wdata[15:0];
            REG_B0:   b0_in   = csr_wdata[29:0];
            REG_A1:   a1_in   = $signed(csr_wdata[30:0]);
            default: begin
            end
         endcase
      end
   end

   // Multiplier operand A.
   always_comb begin
      case (ctl.a_sel)
         A_WHITE: a_op = OP_W'(white_ff);
         A_TAP:   a_op = tap_sel;
         A_N:     a_op = n_ff;
         A_SUMLO: a_op = $signed(OP_W'(sum_ff[SPLIT-1:0]));
         A_SUMHI: a_op = OP_W'($signed(sum_ff[SUM_W-1:SPLIT]));
         A_ACCQ:  a_op = $signed(acc_ff[FRAC_COEF+OP_W-1:FRAC_COEF]);
         A_MEM:   a_op = mem_ff;
         default: a_op = '0;
      endcase
   end

   // Multiplier operand B. The brown feedback b0 - a1 always fits 32 bits.
   always_comb begin
      case (ctl.b_sel)
         B_GAIN:   b_op = $signed(gain_ext);
         B_POLE:   b_op = pole_coef(idx_ff);
         B_FEED:   b_op = feed_coef(idx_ff);
         B_DIRECT: b_op = PINK_DIRECT;
         B_DELAY:  b_op = PINK_DELAY;
         B_SCALE:  b_op = PINK_SCALE;
         B_B0:     b_op = $signed({2'b00, b0_ff});
         B_FB:     b_op = $signed({2'b00, b0_ff} - {a1_ff[30], a1_ff});
         B_G120:   b_op = $signed((gain_ext << 7) - (gain_ext << 3));
         default:  b_op = '0;
      endcase
   end

   // Shared multiplier, registered.
   assign p_in = a_op * b_op;

   // Accumulator. The shifted add rebuilds a product split into two halves.
   always_comb begin
      acc_in = acc_ff;
      if (advance) begin
         case (ctl.acc_op)
            ACC_LOAD:   acc_in = p_ff;
            ACC_ADD:    acc_in = acc_ff + p_ff;
            ACC_ADD_SH: acc_in = acc_ff + (p_ff <<< SPLIT);
            default: begin
            end
         endcase
      end
   end

   // Write-back of filter state, running sum and result.
   always_comb begin
      n_in        = n_ff;
      sum_in      = sum_ff;
      mem_in      = mem_ff;
      rsp_data_in = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      for (int i = 0; i < NUM_TAPS; i++) begin
         taps_in[i] = taps_ff[i];
      end
      if (advance) begin
         case (ctl.wb_op)
            WB_N: begin
               n_in   = OP_W'(acc_ff >>> SHIFT_N);
               sum_in = '0;
            end
            WB_TAP: begin
               for (int i = 0; i < NUM_TAPS; i++) begin
                  if (idx_ff == IDX_W'(i)) begin
                     taps_in[i] = sat_acc;
                  end
               end
               sum_in = sum_ff + SUM_W'(sat_acc);
            end
            WB_SUM_TAP6: begin
               sum_in = sum_ff + SUM_W'(taps_ff[DELAY_TAP]);
            end
            WB_SUM_DIRECT: begin
               sum_in = sum_ff + SUM_W'(acc_ff >>> FRAC_COEF);
            end
            WB_TAP6: begin
               taps_in[DELAY_TAP] = sat_acc;
            end
            WB_MEM: begin
               mem_in = sat_acc;
            end
            WB_OUT_N: begin
               rsp_data_in  = sat_sample(acc_ff >>> OUT_SHIFT_WHITE);
               rsp_valid_in = 1'b1;
            end
            WB_OUT_F: begin
               rsp_data_in  = sat_sample(acc_ff >>> OUT_SHIFT_FILT);
               rsp_valid_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   // Step counter, section index and the conditional jumps.
   always_comb begin
      busy_in  = busy_ff;
      pc_in    = pc_ff;
      idx_in   = idx_ff;
      white_in = white_ff;
      if (req_accept) begin
         busy_in  = 1'b1;
         pc_in    = ADDR_START;
         white_in = $signed(req_tdata[SAMPLE_BITS-1:0]);
      end else if (advance) begin
         case (ctl.idx_op)
            IDX_CLR: idx_in = '0;
            IDX_INC: idx_in = idx_ff + IDX_W'(1);
            default: begin
            end
         endcase
         if (ctl.last) begin
            busy_in = 1'b0;
         end else begin
            case (ctl.jmp)
               JMP_MODE: begin
                  if (mode_ff == MODE_PINK) begin
                     pc_in = ADDR_PINK;
                  end else if (mode_ff == MODE_BROWN) begin
                     pc_in = ADDR_BROWN;
                  end else begin
                     pc_in = pc_ff + PC_W'(1);
                  end
               end
               JMP_LOOP: begin
                  pc_in = (idx_ff != LAST_POLE) ? ctl.target : pc_ff + PC_W'(1);
               end
               default: pc_in = pc_ff + PC_W'(1);
            endcase
         end
      end
   end

   // Control state, configuration and filter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WHITE;
         gain_ff      <= GAIN_RESET;
         b0_ff        <= B0_RESET;
         a1_ff        <= A1_RESET;
         busy_ff      <= 1'b0;
         pc_ff        <= ADDR_START;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mem_ff       <= '0;
         for (int i = 0; i < NUM_TAPS; i++) begin
            taps_ff[i] <= '0;
         end
      end else begin
         mode_ff      <= mode_in;
         gain_ff      <= gain_in;
         b0_ff        <= b0_in;
         a1_ff        <= a1_in;
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
         mem_ff       <= mem_in;
         for (int i = 0; i < NUM_TAPS; i++) begin
            taps_ff[i] <= taps_in[i];
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      white_ff    <= white_in;
      p_ff        <= p_in;
      acc_ff      <= acc_in;
      n_ff        <= n_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// File: rtl/core/cns_checker.sv
// ---------------------------------------------------------------------------
// cns_checker: port-level checks for the noise shaper
// Watches the stream ports over time and is bound to the top level.
// ---------------------------------------------------------------------------
module cns_checker
   import cns_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [DATA_W-1:0]     req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [DATA_W-1:0]     rsp_tdata,
   input logic                  csr_wr_en,
   input logic [CSR_IDX_W-1:0]  csr_index,
   input logic [CSR_DATA_W-1:0] csr_wdata
);

   logic req_fire;
   logic rsp_fire;

   assign req_fire = req_tvalid && req_tready;
   assign rsp_fire = rsp_tvalid && rsp_tready;

   // A result that is not taken holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Only one word is worked on at a time.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_tready)
      else $error("input accepted while a word is in work");

   // Every program takes several steps, so no result appears right after
   // an input word is taken.
   a_no_instant_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_fire))
      else $error("result appeared one cycle after acceptance");

   // When the block is idle and its result is taken, nothing else is pending.
   a_idle_drains: assert property (@(posedge clock) disable iff (reset)
      rsp_fire && req_tready |=> !rsp_tvalid)
      else $error("result appeared with no word in work");

endmodule

bind colored_noise_shaper cns_checker u_cns_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_wr_en  (csr_wr_en),
   .csr_index  (csr_index),
   .csr_wdata  (csr_wdata)
);

// File: tb/tb_colored_noise_shaper.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_colored_noise_shaper: self-checking regression of the noise shaper
// Streams white noise words through every mode and many register settings,
// predicts each word in fixed point and compares it with the block's output.
// ---------------------------------------------------------------------------
module tb_colored_noise_shaper
   import cns_pkg::*;
;

   localparam int HALF_PERIOD  = 2;
   localparam int RESET_CYCLES = 9;
   localparam int PHASES       = 10;
   localparam int PHASE_WORDS  = 70;
   localparam int LONG_HOLD    = 400;
   // Longest program is the pink loop; the settle wait outlasts it, which is
   // enough to catch a stray result after the last expected one.
   localparam int SETTLE_CYCLES = 48;
   localparam int RUN_LIMIT_NS  = 2_000_000;

   // Expected-word store plus the fixed-point model of the shaper datapath.
   // The model keeps its own copy of the registers, updated on each write,
   // and of the pink taps and brown memory, updated per accepted word.
   class noise_scoreboard;
      logic [1:0]         mode;
      logic [15:0]        gain;
      logic [29:0]        b0;
      logic signed [30:0] a1;
      longint             taps[7];
      longint             brown_mem;
      logic [SAMPLE_BITS-1:0] expected_q[$];
      int unsigned        failures;
      int unsigned        checked;
      int unsigned        words_per_mode[4];

      function new();
         mode      = MODE_WHITE;
         gain      = 16'd8231;
         b0        = 30'd701690;
         a1        = -31'sd1072338443;
         brown_mem = 0;
         failures  = 0;
         checked   = 0;
         foreach (taps[i]) taps[i] = 0;
         foreach (words_per_mode[i]) words_per_mode[i] = 0;
      endfunction

      // Register write as the block sees it: bits above each width drop out.
      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_MODE: mode = value[1:0];
            REG_GAIN: gain = value[15:0];
            REG_B0:   b0   = value[29:0];
            REG_A1:   a1   = value[30:0];
            default:  ;
         endcase
      endfunction

      function longint clip32(longint x);
         if (x > 64'sd2147483647) return 64'sd2147483647;
         if (x < -64'sd2147483648) return -64'sd2147483648;
         return x;
      endfunction

      // Pink section coefficients in Q2.30: pole first, then input weight.
      function longint pole_q30(int k);
         case (k)
            0:       return 64'sd1072517758;
            1:       return 64'sd1066569229;
            2:       return 64'sd1040455827;
            3:       return 64'sd930397290;
            4:       return 64'sd590558003;
            default: return -64'sd817761773;
         endcase
      endfunction

      function longint input_q30(int k);
         case (k)
            0:       return 64'sd59611891;
            1:       return 64'sd80612134;
            2:       return 64'sd165197327;
            3:       return 64'sd333381374;
            4:       return 64'sd572253067;
            default: return -64'sd18144089;
         endcase
      endfunction

      // Accepted input word: advance the filter state and queue the result.
      function void note_sample(logic [SAMPLE_BITS-1:0] white);
         logic signed [SAMPLE_BITS-1:0] ws;
         longint w, g, n, y, acc, sum, fb;
         ws = white;
         w  = ws;
         g  = longint'(gain);
         // Gained noise in Q8.24; arithmetic shifts round toward minus infinity.
         n  = (w * g) >>> (SAMPLE_BITS - 1 + 15 - 24);
         y  = n;
         words_per_mode[mode]++;
         case (mode)
            MODE_PINK: begin
               sum = 0;
               for (int k = 0; k < 6; k++) begin
                  acc     = pole_q30(k) * taps[k] + input_q30(k) * n;
                  taps[k] = clip32(acc >>> 30);
                  sum    += taps[k];
               end
               sum    += taps[6];
               sum    += (n * 64'sd575740366) >>> 30;
               taps[6] = clip32((n * 64'sd124474595) >>> 30);
               y = (((sum * 64'sd118111601) >>> 30) * g) >>> 15;
            end
            MODE_BROWN: begin
               fb        = longint'(b0) - longint'(a1);
               acc       = longint'(b0) * n + fb * brown_mem;
               brown_mem = clip32(acc >>> 30);
               y = (brown_mem * 120 * g) >>> 15;
            end
            default: ;  // white, and the spare code behaves as white
         endcase
         y = y >>> (24 - (SAMPLE_BITS - 1));
         if (y > 32767) y = 32767;
         if (y < -32768) y = -32768;
         expected_q.push_back(y[SAMPLE_BITS-1:0]);
      endfunction

      function void check_word(logic [SAMPLE_BITS-1:0] actual);
         logic [SAMPLE_BITS-1:0] want;
         if (expected_q.size() == 0) begin
            $error("shaped_sample: unexpected word, actual %0d", $signed(actual));
            failures++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want !== actual) begin
            $error("shaped_sample: expected %0d, actual %0d", $signed(want), $signed(actual));
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata;   // [SAMPLE_BITS-1:0] white_sample
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [DATA_W-1:0]     rsp_tdata;   // [SAMPLE_BITS-1:0] shaped_sample
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   noise_scoreboard shaper_sb;

   // Flow control shared between the stimulus and the result side. Only the
   // main sequence writes these; the result side just reads them.
   bit steady_flow = 1'b0;
   int hold_requests = 0;
   int burst_left = 0;
   int settings_used = 0;

   colored_noise_shaper uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // Watch both channels at the rising edge. The result is checked before
   // the input is noted so that a result can never match an expectation
   // created at the same edge.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            shaper_sb.check_word(rsp_tdata[SAMPLE_BITS-1:0]);
         end
         if (req_tvalid && req_tready) begin
            shaper_sb.note_sample(req_tdata[SAMPLE_BITS-1:0]);
         end
      end
   end

   // Result side. It stalls on a pattern chosen anew for each window: always
   // ready, a rotating random bit mask, mostly ready, or mostly stalled. A
   // long hold-off request from the main sequence overrides the pattern and
   // keeps tready low until the hold runs out, so the block backs up.
   initial begin : result_side
      int          window;
      int          style;
      int          hold_left;
      int          holds_seen;
      logic [31:0] pattern;
      window     = 0;
      style      = 0;
      hold_left  = 0;
      holds_seen = 0;
      pattern    = '1;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_seen != hold_requests) begin
            holds_seen = hold_requests;
            hold_left  = LONG_HOLD;
         end
         if (window == 0) begin
            window  = 64;
            style   = steady_flow ? 0 : $urandom_range(0, 3);
            pattern = $urandom;
         end
         window--;
         pattern = {pattern[30:0], pattern[31]};
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (style)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= pattern[0];
               2:       rsp_tready <= ($urandom_range(0, 7) != 0);
               default: rsp_tready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // Offer one word and hold it until the block takes it. Words go out in
   // bursts; between bursts tvalid drops for a random gap, which the steady
   // phases skip.
   task automatic send_sample(input logic [SAMPLE_BITS-1:0] sample);
      int gap;
      if (burst_left == 0) begin
         gap = steady_flow ? 0 :
               ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 4);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(sample);
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop tvalid and wait until every expected word has come back, so the
   // block is idle before the registers change.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (shaper_sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shaper_sb.write_reg(idx, value);
   endtask

   // A fresh random setting of all four registers. Unused high bits are
   // filled at random since the block must ignore them. Most brown settings
   // keep the feedback below one so the memory stays in range; the rest are
   // arbitrary and usually drive the memory into saturation.
   task automatic random_settings();
      int b0_val;
      int fb_val;
      logic [CSR_DATA_W-1:0] gain_word;
      logic [CSR_DATA_W-1:0] b0_word;
      logic [CSR_DATA_W-1:0] a1_word;
      case ($urandom_range(0, 5))
         0:       gain_word = '0;
         1:       gain_word = 31'h7FFF_FFFF;
         2:       gain_word = 31'd8231;
         default: gain_word = $urandom;
      endcase
      if ($urandom_range(0, 4) == 0) begin
         b0_word = $urandom;
         a1_word = $urandom;
      end else begin
         b0_val  = $urandom_range(0, 1 << 22);
         fb_val  = (1 << 30) - $urandom_range(1, 1 << 21);
         b0_word = ($urandom & 32'h4000_0000) | b0_val;
         a1_word = b0_val - fb_val;
      end
      write_reg(REG_MODE, $urandom);
      write_reg(REG_GAIN, gain_word);
      write_reg(REG_B0, b0_word);
      write_reg(REG_A1, a1_word);
      settings_used++;
   endtask

   // Mostly full-range random samples, with the two extremes and the values
   // around zero mixed in.
   task automatic random_words(input int count);
      logic [SAMPLE_BITS-1:0] sample;
      for (int k = 0; k < count; k++) begin
         case ($urandom_range(0, 15))
            0:       sample = 16'h7FFF;
            1:       sample = 16'h8000;
            2:       sample = SAMPLE_BITS'($signed($urandom_range(0, 4)) - 2);
            default: sample = $urandom;
         endcase
         send_sample(sample);
      end
   endtask

   initial begin : timeout_guard
      #(RUN_LIMIT_NS);
      $display("colored_noise_shaper regression: fail");
      $finish;
   end

   initial begin : main_sequence
      shaper_sb  = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = REG_MODE;
      csr_wdata  = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part. Reset settings first: white mode at the default gain,
      // with both sample extremes, zero, plus and minus one, and bit patterns.
      steady_flow = 1'b1;
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h0000);
      send_sample(16'hFFFF);
      send_sample(16'h0001);
      send_sample(16'h5555);
      send_sample(16'hAAAA);
      drain();

      // Spare mode code and full gain, both written with every high bit set.
      write_reg(REG_MODE, 31'h7FFF_FFFF);
      write_reg(REG_GAIN, 31'h7FFF_FFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      send_sample(16'h3039);
      drain();

      // Pink with zero gain, then at full gain with the most negative sample.
      write_reg(REG_MODE, 31'h7FFF_FFFD);
      write_reg(REG_GAIN, '0);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      drain();
      write_reg(REG_GAIN, 31'h0000_FFFF);
      repeat (4) send_sample(16'h8000);
      drain();

      // Brown with the largest input coefficient and the most negative a1,
      // so the loop gain is near two and the memory saturates.
      write_reg(REG_MODE, MODE_BROWN);
      write_reg(REG_B0, 31'h7FFF_FFFF);
      write_reg(REG_A1, 31'h4000_0000);
      repeat (3) send_sample(16'h7FFF);
      send_sample(16'h8000);
      drain();

      // Back to the mildest settings: zero input weight and the largest a1,
      // for a feedback near minus one, which leaves the brown memory decaying.
      write_reg(REG_B0, '0);
      write_reg(REG_A1, 31'h3FFF_FFFF);
      send_sample(16'h7FFF);
      send_sample(16'h8000);
      drain();

      // Random part: one register setting per phase. The first phase runs
      // with no idling at all; the third holds the result side off for a
      // long stretch while the input keeps offering words.
      for (int phase = 0; phase < PHASES; phase++) begin
         random_settings();
         steady_flow = (phase == 0) || (phase == 2);
         if (phase == 2) begin
            hold_requests++;
         end
         random_words(PHASE_WORDS);
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (shaper_sb.pending() != 0) begin
         $error("shaped_sample: %0d expected words never arrived", shaper_sb.pending());
      end

      $display("Sent %0d white, %0d pink, %0d brown and %0d spare-mode words over %0d settings.",
               shaper_sb.words_per_mode[MODE_WHITE], shaper_sb.words_per_mode[MODE_PINK],
               shaper_sb.words_per_mode[MODE_BROWN], shaper_sb.words_per_mode[3],
               settings_used + 6);
      $display("Compared %0d shaped words, %0d mismatched.", shaper_sb.checked,
               shaper_sb.failures);
      if (shaper_sb.failures == 0 && shaper_sb.pending() == 0) begin
         $display("colored_noise_shaper regression: pass");
      end else begin
         $display("colored_noise_shaper regression: fail");
      end
      $finish;
   end

endmodule

// File: sim.f
rtl/core/cns_pkg.sv
rtl/core/colored_noise_shaper.sv
rtl/core/cns_checker.sv
tb/tb_colored_noise_shaper.sv
